>>> design/brf_pkg.sv
// shared constants for the byte ring fifo
`timescale 1ns / 1ps
package brf_pkg;
	localparam int unsigned DEPTH_DEF = 4096;
	localparam int unsigned MAX_BLOCK_DEF = 8;
	localparam int unsigned CMD_W = 3;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned OFF_W = 12;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned NB_W = 4;

	localparam logic [CMD_W-1:0] CMD_PUT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GET = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FIND = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_ROOM = 2'd1;
	localparam logic [STAT_W-1:0] ST_DATA = 2'd2;
	localparam logic [STAT_W-1:0] ST_LONG = 2'd3;
endpackage

>>> design/brf_ram.sv
// generic single-port-write, one-read ram with registered read
`timescale 1ns / 1ps
module brf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> design/byte_ring_fifo_with_marker_search.sv
// byte ring fifo with block put/get/peek, discard, clear and marker search
// put, get and peek of n bytes run in steps: accept, one ram access per byte, result
// discard, clear, zero-length reads and refused commands go from accept straight to the result
// find walks the stored bytes from the read point, one ram read per cycle, as the
// single read port of the byte ram allows
// one command at a time; the result register frees the input once it is taken
// arst_n empties the ring; ram contents stay undefined until written
`timescale 1ns / 1ps
module byte_ring_fifo_with_marker_search #(
	parameter int unsigned DEPTH = brf_pkg::DEPTH_DEF,
	parameter int unsigned MAX_BLOCK = brf_pkg::MAX_BLOCK_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [brf_pkg::CMD_W-1:0]   command,
	input  logic [brf_pkg::CNT_W-1:0]   byte_count,
	input  logic [63:0]                 data_in,
	input  logic [31:0]                 marker,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [brf_pkg::STAT_W-1:0]  status,
	output logic [63:0]                 data_out,
	output logic [brf_pkg::NB_W-1:0]    bytes_out,
	output logic                        marker_found,
	output logic [brf_pkg::OFF_W-1:0]   marker_offset,
	output logic [brf_pkg::CNT_W-1:0]   stored_bytes,
	output logic [brf_pkg::CNT_W-1:0]   free_bytes
);
	import brf_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned PW = AW + 1;
	localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PUT = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_FIND = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0] state_q;
	logic [PW-1:0] wr_q, rd_q;
	logic [PW-1:0] stored;
	logic [CMD_W-1:0] cmd_q;
	logic [63:0] din_q;
	logic [31:0] mk_q;
	logic [3:0] n_q;
	logic [3:0] i_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] lim_q;
	logic [31:0] win_q;
	logic [PW-1:0] seen_q;
	logic out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [63:0] dout_q;
	logic [NB_W-1:0] nb_q;
	logic found_q;
	logic [OFF_W-1:0] off_q;
	logic [CNT_W-1:0] sb_q, fb_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;
	logic accept, out_free;
	logic [PW-1:0] cnt_p;
	logic cnt_big;
	logic [31:0] win_next;
	logic [PW-1:0] stored_fin;

	brf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign stored = wr_q - rd_q;
	assign stored_fin = stored;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept = in_valid && !in_stall;
	assign cnt_big = (CNT_W > PW) ? (byte_count > CNT_W'(DEPTH)) : 1'b0;
	assign cnt_p = PW'(byte_count);
	assign win_next = {ram_rdata, win_q[31:8]};

	assign ram_we = (state_q == S_PUT);
	assign ram_waddr = AW'(wr_q + PW'(i_q));
	assign ram_wdata = din_q[8*i_q[2:0] +: 8];
	// first byte at the read point is fetched on the accepting edge
	assign ram_raddr = (state_q == S_IDLE) ? AW'(rd_q) : AW'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wr_q <= '0;
			rd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= command;
						din_q <= data_in;
						mk_q <= marker;
						i_q <= '0;
						pos_q <= rd_q;
						seen_q <= '0;
						win_q <= '0;
						dout_q <= '0;
						nb_q <= '0;
						found_q <= 1'b0;
						off_q <= '0;
						status_q <= ST_OK;
						state_q <= S_OUT;
						case (command) inside
							CMD_PUT: begin
								if (byte_count == '0) begin
									status_q <= ST_ROOM;
								end else if (byte_count > CNT_W'(MAX_BLOCK)) begin
									status_q <= ST_LONG;
								end else if (DEPTH_P - stored < cnt_p) begin
									status_q <= ST_ROOM;
								end else begin
									n_q <= 4'(byte_count);
									state_q <= S_PUT;
								end
							end
							CMD_GET, CMD_PEEK: begin
								if (byte_count > CNT_W'(MAX_BLOCK)) begin
									status_q <= ST_LONG;
								end else if (command == CMD_GET && stored < cnt_p) begin
									status_q <= ST_DATA;
								end else begin
									n_q <= (stored < cnt_p) ? 4'(stored) : 4'(byte_count);
									nb_q <= (stored < cnt_p) ? 4'(stored) : 4'(byte_count);
									lim_q <= (stored < cnt_p) ? stored : cnt_p;
									if (((stored < cnt_p) ? stored : cnt_p) != '0) begin
										state_q <= S_RD;
										pos_q <= rd_q + 1'b1;
									end
								end
							end
							CMD_DISCARD: begin
								if (cnt_big || cnt_p > stored) begin
									status_q <= ST_DATA;
									rd_q <= wr_q;
								end else begin
									rd_q <= rd_q + cnt_p;
								end
							end
							CMD_CLEAR: rd_q <= wr_q;
							CMD_FIND: begin
								lim_q <= stored;
								if (stored >= PW'(4)) begin
									state_q <= S_FIND;
									pos_q <= rd_q + 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_PUT: begin
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == n_q) begin
						wr_q <= wr_q + PW'(n_q);
						state_q <= S_OUT;
					end
				end
				S_RD: begin
					dout_q[8*i_q[2:0] +: 8] <= ram_rdata;
					i_q <= i_q + 1'b1;
					if (PW'(i_q) + 1'b1 < lim_q) begin
						pos_q <= pos_q + 1'b1;
					end else begin
						if (cmd_q == CMD_GET) begin
							rd_q <= rd_q + PW'(n_q);
						end
						state_q <= S_OUT;
					end
				end
				S_FIND: begin
					win_q <= win_next;
					seen_q <= seen_q + 1'b1;
					if (seen_q >= PW'(3) && win_next == mk_q) begin
						found_q <= 1'b1;
						off_q <= OFF_W'(seen_q - PW'(3));
						state_q <= S_OUT;
					end else if (seen_q + 1'b1 == lim_q) begin
						state_q <= S_OUT;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						sb_q <= CNT_W'(stored_fin);
						fb_q <= CNT_W'(DEPTH_P - stored_fin);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign data_out = dout_q;
	assign bytes_out = nb_q;
	assign marker_found = found_q;
	assign marker_offset = off_q;
	assign stored_bytes = sb_q;
	assign free_bytes = fb_q;
endmodule

>>> design/brf_checker.sv
// port-level checks for the byte ring fifo, bound to the top level
`timescale 1ns / 1ps
module brf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [brf_pkg::NB_W-1:0]    bytes_out,
	input logic [brf_pkg::CNT_W-1:0]   stored_bytes,
	input logic [brf_pkg::CNT_W-1:0]   free_bytes,
	input logic                        marker_found,
	input logic [brf_pkg::OFF_W-1:0]   marker_offset
);
	import brf_pkg::*;

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (14'(stored_bytes) + 14'(free_bytes) == 14'(DEPTH_DEF)))
		else $error("stored plus free mismatch");
	a_nb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bytes_out <= NB_W'(MAX_BLOCK_DEF)))
		else $error("bytes_out too large");
	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !marker_found) |-> (marker_offset == '0))
		else $error("offset without match");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(stored_bytes)))
		else $error("stalled result changed");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input open while result stalled");
endmodule

bind byte_ring_fifo_with_marker_search brf_checker u_brf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.bytes_out     (bytes_out),
	.stored_bytes  (stored_bytes),
	.free_bytes    (free_bytes),
	.marker_found  (marker_found),
	.marker_offset (marker_offset)
);
